// ----- hw/rtl/rpn_pkg.sv -----
// Shared types, constants and the command and status codes of the calculator.
package rpn_pkg;

    localparam int STACK_DEPTH = 128;
    localparam int FRAC_BITS   = 16;
    localparam int PTR_W       = $clog2(STACK_DEPTH + 1);
    localparam int DIV_STEPS   = 32 + FRAC_BITS + 1;
    localparam int DCNT_W      = $clog2(DIV_STEPS + 1);

    typedef enum logic [2:0] {
        KIND_PUSH    = 3'd0,
        KIND_ADD     = 3'd1,
        KIND_SUB     = 3'd2,
        KIND_MUL     = 3'd3,
        KIND_DIV     = 3'd4,
        KIND_PRINT   = 3'd5,
        KIND_UNKNOWN = 3'd6,
        KIND_SPARE   = 3'd7
    } kind_t;

    typedef enum logic [1:0] {
        ST_DONE    = 2'd0,
        ST_PRINTED = 2'd1,
        ST_ZERODIV = 2'd2,
        ST_UNKNOWN = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_POP1,
        S_POP2,
        S_MUL,
        S_MUL2,
        S_DIV,
        S_DIV2,
        S_PUSH,
        S_REPORT
    } state_t;

    // Control from the sequencer to the cells of the stack
    typedef struct packed {
        logic        push;
        logic        pop;
        logic [31:0] data;
    } stk_ctl_t;

    // Clamp a 64-bit signed value to the signed 32-bit range
    function automatic logic [31:0] sat32(input logic signed [63:0] v);
        logic [31:0] r;
        if (v > 64'sd2147483647)
            r = 32'h7fff_ffff;
        else if (v < -64'sd2147483648)
            r = 32'h8000_0000;
        else
            r = v[31:0];
        return r;
    endfunction

endpackage

// ----- hw/rtl/rpn_stack_calculator_unit.sv -----
// Top level of the RPN stack calculator: sequencer, arithmetic and cell stack.
//
// One command is transferred when start is high and busy is low. Exactly one
// result follows, shown for one cycle with done high; the receiver cannot
// stall it. Values are signed Q16.16, arithmetic saturates. The stack is a row
// of 128 cells, top at cell 0, shifting one place per push or pop cycle.
// Paths, each ending in REPORT: unknown goes there at once; push via PUSH;
// print and a zero divisor via POP1; add and subtract via POP1, POP2, MUL2,
// PUSH; multiply also MUL (one 32x32 multiply, then rounding); divide POP1,
// POP2, DIV, DIV2, PUSH; a restoring divider gives one quotient bit per cycle.
// busy stays high from the transfer through the cycle that shows the result,
// so the next transfer can come in the cycle after done.
module rpn_stack_calculator_unit
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [2:0]          kind,
    input  logic signed [31:0]  operand_value,
    output logic                done,
    output logic [1:0]          status,
    output logic [1:0]          underflow_count,
    output logic                overflow,
    output logic signed [31:0]  shown_value
);

    localparam int PW = rpn_pkg::PTR_W;
    localparam int NW = 32 + rpn_pkg::FRAC_BITS + 1;  // 2*|a|<<F width
    localparam int DW = 34;                           // 2*|b| width plus sign room

    rpn_pkg::state_t state_reg, state_next;
    rpn_pkg::kind_t  kind_reg, kind_next;
    logic [PW-1:0]   sp_reg, sp_next;
    logic [31:0]     opa_reg, opa_next;     // left operand / push data
    logic [31:0]     opb_reg, opb_next;     // right operand
    logic [1:0]      under_reg, under_next;
    logic            over_reg, over_next;
    logic [1:0]      status_reg, status_next;
    logic [31:0]     shown_reg, shown_next;
    logic            done_reg, done_next;
    logic signed [63:0] prod_reg, prod_next;
    logic [NW-1:0]   quo_reg, quo_next;     // shifting dividend / quotient
    logic [DW-1:0]   rem_reg, rem_next;
    logic [rpn_pkg::DCNT_W-1:0] cnt_reg, cnt_next;
    logic            neg_reg, neg_next;

    rpn_pkg::stk_ctl_t ctl;
    logic [31:0]       top;

    rpn_stack u_stack
    (
        .clk (clk),
        .ctl (ctl),
        .top (top)
    );

    // Arithmetic helpers
    logic [63:0] pmag;
    logic [63:0] mrnd;
    logic [63:0] qext;
    logic [32:0] amag, bmag;
    logic [DW-1:0] rtry;
    logic [DW-1:0] dsor;
    logic [DW:0]   rdiff;

    always_comb
    begin
        pmag  = prod_reg[63] ? 64'(-prod_reg) : 64'(prod_reg);
        mrnd  = (pmag + ((rpn_pkg::FRAC_BITS > 0) ?
                 (64'd1 << (rpn_pkg::FRAC_BITS - 1)) : 64'd0)) >> rpn_pkg::FRAC_BITS;
        amag  = opa_reg[31] ? 33'(-{1'b1, opa_reg}) : {1'b0, opa_reg};
        bmag  = opb_reg[31] ? 33'(-{1'b1, opb_reg}) : {1'b0, opb_reg};
        dsor  = DW'({bmag, 1'b0});
        rtry  = {rem_reg[DW-2:0], quo_reg[NW-1]};
        rdiff = {1'b0, rtry} - {1'b0, dsor};
        qext  = 64'(quo_reg);
    end

    // Saturate a magnitude with sign to 32 bits
    function automatic logic [31:0] from_mag(input logic neg, input logic [63:0] m);
        logic [63:0] c;
        c = (m > 64'h1_0000_0000) ? 64'h1_0000_0000 : m;
        return rpn_pkg::sat32(neg ? 64'(-c) : c);
    endfunction

    // Next-state logic
    always_comb
    begin
        state_next  = state_reg;
        kind_next   = kind_reg;
        sp_next     = sp_reg;
        opa_next    = opa_reg;
        opb_next    = opb_reg;
        under_next  = under_reg;
        over_next   = over_reg;
        status_next = status_reg;
        shown_next  = shown_reg;
        prod_next   = prod_reg;
        quo_next    = quo_reg;
        rem_next    = rem_reg;
        cnt_next    = cnt_reg;
        neg_next    = neg_reg;
        case (state_reg)
            rpn_pkg::S_IDLE:
            begin
                // no transfer while the previous result is still on show
                if (start && !done_reg)
                begin
                    kind_next   = rpn_pkg::kind_t'(kind);
                    opa_next    = operand_value;
                    under_next  = '0;
                    over_next   = 1'b0;
                    status_next = rpn_pkg::ST_DONE;
                    shown_next  = '0;
                    case (rpn_pkg::kind_t'(kind))
                        rpn_pkg::KIND_PUSH:
                            state_next = rpn_pkg::S_PUSH;
                        rpn_pkg::KIND_ADD, rpn_pkg::KIND_SUB, rpn_pkg::KIND_MUL,
                        rpn_pkg::KIND_DIV, rpn_pkg::KIND_PRINT:
                            state_next = rpn_pkg::S_POP1;
                        default:
                        begin
                            status_next = rpn_pkg::ST_UNKNOWN;
                            state_next  = rpn_pkg::S_REPORT;
                        end
                    endcase
                end
            end
            rpn_pkg::S_POP1:
            begin
                if (sp_reg != '0)
                begin
                    opb_next = top;
                    sp_next  = sp_reg - PW'(1);
                end
                else
                begin
                    opb_next   = '0;
                    under_next = under_reg + 2'd1;
                end
                if (kind_reg == rpn_pkg::KIND_PRINT)
                begin
                    shown_next  = (sp_reg != '0) ? top : 32'd0;
                    status_next = rpn_pkg::ST_PRINTED;
                    state_next  = rpn_pkg::S_REPORT;
                end
                else if (kind_reg == rpn_pkg::KIND_DIV && (sp_reg == '0 || top == '0))
                begin
                    status_next = rpn_pkg::ST_ZERODIV;
                    state_next  = rpn_pkg::S_REPORT;
                end
                else
                    state_next = rpn_pkg::S_POP2;
            end
            rpn_pkg::S_POP2:
            begin
                if (sp_reg != '0)
                begin
                    opa_next = top;
                    sp_next  = sp_reg - PW'(1);
                end
                else
                begin
                    opa_next   = '0;
                    under_next = under_reg + 2'd1;
                end
                case (kind_reg)
                    rpn_pkg::KIND_MUL: state_next = rpn_pkg::S_MUL;
                    rpn_pkg::KIND_DIV: state_next = rpn_pkg::S_DIV;
                    default:           state_next = rpn_pkg::S_MUL2;
                endcase
            end
            rpn_pkg::S_MUL:
            begin
                prod_next  = $signed(opa_reg) * $signed(opb_reg);
                state_next = rpn_pkg::S_MUL2;
            end
            rpn_pkg::S_MUL2:
            begin
                // Result forming for add, subtract and multiply
                case (kind_reg)
                    rpn_pkg::KIND_ADD:
                        opa_next = rpn_pkg::sat32(64'($signed(opa_reg)) + 64'($signed(opb_reg)));
                    rpn_pkg::KIND_SUB:
                        opa_next = rpn_pkg::sat32(64'($signed(opa_reg)) - 64'($signed(opb_reg)));
                    default:
                        opa_next = from_mag(prod_reg[63], mrnd);
                endcase
                state_next = rpn_pkg::S_PUSH;
            end
            rpn_pkg::S_DIV:
            begin
                // q = (2n + d) / (2d): dividend is 2*|a|<<F + |b|
                quo_next   = NW'((64'(amag) << (rpn_pkg::FRAC_BITS + 1)) + 64'(bmag));
                rem_next   = '0;
                cnt_next   = '0;
                neg_next   = opa_reg[31] ^ opb_reg[31];
                state_next = rpn_pkg::S_DIV2;
            end
            rpn_pkg::S_DIV2:
            begin
                if (cnt_reg == rpn_pkg::DCNT_W'(NW))
                begin
                    opa_next   = from_mag(neg_reg, qext);
                    state_next = rpn_pkg::S_PUSH;
                end
                else
                begin
                    if (!rdiff[DW])
                    begin
                        rem_next = rdiff[DW-1:0];
                        quo_next = {quo_reg[NW-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_next = rtry;
                        quo_next = {quo_reg[NW-2:0], 1'b0};
                    end
                    cnt_next = cnt_reg + rpn_pkg::DCNT_W'(1);
                end
            end
            rpn_pkg::S_PUSH:
            begin
                if (sp_reg < PW'(rpn_pkg::STACK_DEPTH))
                    sp_next = sp_reg + PW'(1);
                else
                    over_next = 1'b1;
                state_next = rpn_pkg::S_REPORT;
            end
            rpn_pkg::S_REPORT:
                state_next = rpn_pkg::S_IDLE;
            default:
                state_next = rpn_pkg::S_IDLE;
        endcase
        // overflow only reported for the push command
        if (state_reg == rpn_pkg::S_PUSH && kind_reg != rpn_pkg::KIND_PUSH)
            over_next = 1'b0;
    end

    // Output and stack control logic
    always_comb
    begin
        ctl.push  = 1'b0;
        ctl.pop   = 1'b0;
        ctl.data  = opa_reg;
        done_next = 1'b0;
        case (state_reg)
            rpn_pkg::S_POP1, rpn_pkg::S_POP2:
                ctl.pop = (sp_reg != '0);
            rpn_pkg::S_PUSH:
                ctl.push = (sp_reg < PW'(rpn_pkg::STACK_DEPTH));
            rpn_pkg::S_REPORT:
                done_next = 1'b1;
            default:
                ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rpn_pkg::S_IDLE;
            sp_reg    <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            sp_reg    <= sp_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg   <= kind_next;
        opa_reg    <= opa_next;
        opb_reg    <= opb_next;
        under_reg  <= under_next;
        over_reg   <= over_next;
        status_reg <= status_next;
        shown_reg  <= shown_next;
        prod_reg   <= prod_next;
        quo_reg    <= quo_next;
        rem_reg    <= rem_next;
        cnt_reg    <= cnt_next;
        neg_reg    <= neg_next;
    end

    assign busy            = (state_reg != rpn_pkg::S_IDLE) || done_reg;
    assign done            = done_reg;
    assign status          = status_reg;
    assign underflow_count = under_reg;
    assign overflow        = over_reg;
    assign shown_value     = shown_reg;

endmodule

// ----- hw/rtl/rpn_cell.sv -----
// One stack cell: holds one entry and shifts with its neighbors on push or pop.
module rpn_cell
(
    input  logic                 clk,
    input  rpn_pkg::stk_ctl_t    ctl,
    input  logic [31:0]          above,
    input  logic [31:0]          below,
    output logic [31:0]          value
);

    logic [31:0] value_reg;
    logic [31:0] value_next;

    always_comb
    begin
        value_next = value_reg;
        if (ctl.push)
            value_next = above;
        else if (ctl.pop)
            value_next = below;
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign value = value_reg;

endmodule

// ----- hw/rtl/rpn_stack.sv -----
// Stack as a row of cells; cell 0 is the top, data moves one cell per push or pop.
module rpn_stack
(
    input  logic                 clk,
    input  rpn_pkg::stk_ctl_t    ctl,
    output logic [31:0]          top
);

    logic [31:0] vals [rpn_pkg::STACK_DEPTH];

    genvar g;
    generate
        for (g = 0; g < rpn_pkg::STACK_DEPTH; g++)
        begin : g_cell
            logic [31:0] above_w;
            logic [31:0] below_w;
            if (g == 0)
            begin : g_top
                assign above_w = ctl.data;
            end
            else
            begin : g_mid
                assign above_w = vals[g-1];
            end
            if (g == rpn_pkg::STACK_DEPTH - 1)
            begin : g_bot
                assign below_w = '0;
            end
            else
            begin : g_up
                assign below_w = vals[g+1];
            end
            rpn_cell u_cell
            (
                .clk   (clk),
                .ctl   (ctl),
                .above (above_w),
                .below (below_w),
                .value (vals[g])
            );
        end
    endgenerate

    assign top = vals[0];

endmodule
